### rtl/core/ufbs_pkg.sv
package ufbs_pkg;

    localparam int MAX_DIVISOR   = 65535;
    localparam int MASK_BITS     = 12;
    localparam int FRACTION_BITS = 36;

    localparam int NOMINAL_SAMPLES = 16;
    localparam int MAX_SAMPLES     = 32;
    localparam int MIN_SAMPLES     = 4;
    localparam int START_MULT      = MAX_SAMPLES + 1;

    localparam int CLK_W  = 31;
    localparam int BAUD_W = 24;
    localparam int DIV_W  = 16;
    localparam int SPB_W  = 6;
    localparam int DIVC_W = DIV_W + 1;
    localparam int DIST_W = 5;

    localparam int IN_TDATA_W  = ((CLK_W + BAUD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = DIV_W + SPB_W + MASK_BITS;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    // divider: dividend up to spb*div*2^F, divisor up to baud*div
    localparam int DVD_W = SPB_W + DIV_W + FRACTION_BITS;
    localparam int DVS_W = BAUD_W + DIV_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // mask datapath
    localparam int SUM_W = $clog2(MASK_BITS * (MAX_SAMPLES + 1) + 1);
    localparam int ACC_W = SUM_W + DIV_W + FRACTION_BITS;
    localparam int T1_W  = $clog2(MASK_BITS + 1) + FRACTION_BITS;
    localparam int P_W   = FRACTION_BITS + 1;
    localparam int B_W   = DIV_W + FRACTION_BITS;
    localparam int BIT_W = $clog2(MASK_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXACT,
        S_START,
        S_RECIP,
        S_MUL,
        S_SPB,
        S_AQ,
        S_BQ,
        S_MASK,
        S_RESULT
    } t_seq_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_T2,
        M_SUM,
        M_DEC
    } t_mask_state;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;  // aligned to the top bit
        logic [DVS_W-1:0] divisor;
        logic [CNT_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic [DVD_W-1:0]  a_quot;
        logic [CLK_W-1:0]  a_rem;
        logic [B_W-1:0]    b_quot;
        logic [CLK_W-1:0]  b_rem;
        logic [P_W-1:0]    p_quot;
        logic [BAUD_W-1:0] p_rem;
    } t_mask_op;

    typedef struct packed {
        logic                 found;
        logic [MASK_BITS-1:0] mask;
        logic [SPB_W-1:0]     spb;
        logic [DIV_W-1:0]     divisor;
    } t_result;

    function automatic logic [DIST_W-1:0] dist16(input logic [SPB_W-1:0] s);
        logic [SPB_W-1:0] d;
        if (s >= SPB_W'(NOMINAL_SAMPLES)) begin
            d = s - SPB_W'(NOMINAL_SAMPLES);
        end else begin
            d = SPB_W'(NOMINAL_SAMPLES) - s;
        end
        return d[DIST_W-1:0];
    endfunction

endpackage

### rtl/core/ufbs_divider.sv
module ufbs_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ufbs_pkg::t_div_req  i_req,
    output ufbs_pkg::t_div_rsp  o_rsp
);

    localparam int DVD_W = ufbs_pkg::DVD_W;
    localparam int DVS_W = ufbs_pkg::DVS_W;
    localparam int CNT_W = ufbs_pkg::CNT_W;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;

    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] diff;
    logic           ge;

    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = rem_sh >= {1'b0, r_dvs};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;

        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.nbits;
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DVD_W-2:0], ge};
            n_rem = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

### rtl/core/ufbs_mask.sv
module ufbs_mask (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  ufbs_pkg::t_mask_op                 i_op,
    input  logic [ufbs_pkg::CLK_W-1:0]         i_clock,
    input  logic [ufbs_pkg::BAUD_W-1:0]        i_baud,
    output logic                               o_done,
    output logic [ufbs_pkg::MASK_BITS-1:0]     o_mask
);

    localparam int CLK_W     = ufbs_pkg::CLK_W;
    localparam int BAUD_W    = ufbs_pkg::BAUD_W;
    localparam int ACC_W     = ufbs_pkg::ACC_W;
    localparam int T1_W      = ufbs_pkg::T1_W;
    localparam int BIT_W     = ufbs_pkg::BIT_W;
    localparam int MASK_BITS = ufbs_pkg::MASK_BITS;

    ufbs_pkg::t_mask_state r_state, n_state;

    logic                 r_done, n_done;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [T1_W-1:0]      r_t1, n_t1;
    logic [BAUD_W-1:0]    r_r1, n_r1;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [CLK_W-1:0]     r_rem, n_rem;
    logic [ACC_W-1:0]     r_t2, n_t2;
    logic [ACC_W:0]       r_sum, n_sum;
    logic [MASK_BITS-1:0] r_mask, n_mask;

    logic [BAUD_W:0] r1_sum, r1_red;
    logic            c0;
    logic [CLK_W:0]  rem_sum, rem_red;
    logic            c1;
    logic [CLK_W:0]  rem2_sum, rem2_red;
    logic            c2;
    logic            stretch;

    always_comb begin
        r1_sum   = {1'b0, r_r1} + {1'b0, i_op.p_rem};
        c0       = r1_sum >= {1'b0, i_baud};
        r1_red   = c0 ? r1_sum - {1'b0, i_baud} : r1_sum;
        rem_sum  = {1'b0, r_rem} + {1'b0, i_op.a_rem};
        c1       = rem_sum >= {1'b0, i_clock};
        rem_red  = c1 ? rem_sum - {1'b0, i_clock} : rem_sum;
        rem2_sum = {1'b0, r_rem} + {1'b0, i_op.b_rem};
        c2       = rem2_sum >= {1'b0, i_clock};
        rem2_red = c2 ? rem2_sum - {1'b0, i_clock} : rem2_sum;
        stretch  = (ACC_W + 1)'(r_t1) > r_sum;

        n_state = r_state;
        n_done  = 1'b0;
        n_bit   = r_bit;
        n_t1    = r_t1;
        n_r1    = r_r1;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_t2    = r_t2;
        n_sum   = r_sum;
        n_mask  = r_mask;

        case (r_state)
            ufbs_pkg::M_IDLE: begin
                if (i_start) begin
                    n_bit   = '0;
                    n_t1    = '0;
                    n_r1    = '0;
                    n_acc   = '0;
                    n_rem   = '0;
                    n_mask  = '0;
                    n_state = ufbs_pkg::M_T2;
                end
            end
            ufbs_pkg::M_T2: begin
                // bit time target and sample position up to this bit
                n_t1    = r_t1 + T1_W'(i_op.p_quot) + T1_W'(c0);
                n_r1    = r1_red[BAUD_W-1:0];
                n_t2    = r_acc + ACC_W'(i_op.a_quot) + ACC_W'(c1);
                n_rem   = rem_red[CLK_W-1:0];
                n_state = ufbs_pkg::M_SUM;
            end
            ufbs_pkg::M_SUM: begin
                n_sum   = (ACC_W + 1)'(r_t2) + (ACC_W + 1)'(i_op.b_quot >> 1);
                n_state = ufbs_pkg::M_DEC;
            end
            ufbs_pkg::M_DEC: begin
                n_mask = {stretch, r_mask[MASK_BITS-1:1]};
                if (stretch) begin
                    n_acc = r_t2 + ACC_W'(i_op.b_quot) + ACC_W'(c2);
                    n_rem = rem2_red[CLK_W-1:0];
                end else begin
                    n_acc = r_t2;
                end
                if (r_bit == BIT_W'(MASK_BITS - 1)) begin
                    n_done  = 1'b1;
                    n_state = ufbs_pkg::M_IDLE;
                end else begin
                    n_bit   = r_bit + BIT_W'(1);
                    n_state = ufbs_pkg::M_T2;
                end
            end
            default: begin
                n_state = ufbs_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufbs_pkg::M_IDLE;
            r_done  <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1   <= n_t1;
        r_r1   <= n_r1;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_t2   <= n_t2;
        r_sum  <= n_sum;
        r_mask <= n_mask;
    end

    assign o_done = r_done;
    assign o_mask = r_mask;

endmodule

### rtl/core/ufbs_seq.sv
module ufbs_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ufbs_pkg::CLK_W-1:0]   i_clock,
    input  logic [ufbs_pkg::BAUD_W-1:0]  i_baud,
    output logic                         o_idle,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output ufbs_pkg::t_result            o_res
);

    localparam int CLK_W     = ufbs_pkg::CLK_W;
    localparam int BAUD_W    = ufbs_pkg::BAUD_W;
    localparam int DIV_W     = ufbs_pkg::DIV_W;
    localparam int DIVC_W    = ufbs_pkg::DIVC_W;
    localparam int SPB_W     = ufbs_pkg::SPB_W;
    localparam int DIST_W    = ufbs_pkg::DIST_W;
    localparam int DVD_W     = ufbs_pkg::DVD_W;
    localparam int DVS_W     = ufbs_pkg::DVS_W;
    localparam int CNT_W     = ufbs_pkg::CNT_W;
    localparam int B_W       = ufbs_pkg::B_W;
    localparam int P_W       = ufbs_pkg::P_W;
    localparam int FRAC      = ufbs_pkg::FRACTION_BITS;
    localparam int MASK_BITS = ufbs_pkg::MASK_BITS;
    localparam int SD_W      = SPB_W + DIV_W;

    ufbs_pkg::t_seq_state r_state, n_state;

    logic [CLK_W-1:0]     r_clock, n_clock;
    logic [BAUD_W-1:0]    r_baud, n_baud;
    logic [DIVC_W-1:0]    r_div, n_div;
    logic [SPB_W-1:0]     r_spb, n_spb;
    ufbs_pkg::t_mask_op   r_op, n_op;
    ufbs_pkg::t_result    r_best, n_best;
    logic [DIST_W-1:0]    r_best_dist, n_best_dist;

    ufbs_pkg::t_div_req   div_req;
    ufbs_pkg::t_div_rsp   div_rsp;
    logic                 mask_start;
    logic                 mask_done;
    logic [MASK_BITS-1:0] mask;

    logic [DVS_W-1:0]  bd;
    logic [SD_W-1:0]   sd;
    logic [SPB_W-1:0]  q_spb;
    logic [DIST_W-1:0] q_dist;
    logic [DIST_W-1:0] cur_dist;

    ufbs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ufbs_mask u_mask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mask_start),
        .i_op    (r_op),
        .i_clock (r_clock),
        .i_baud  (r_baud),
        .o_done  (mask_done),
        .o_mask  (mask)
    );

    always_comb begin
        bd       = DVS_W'(r_baud) * DVS_W'(r_div[DIV_W-1:0]);
        q_spb    = div_rsp.quot[SPB_W-1:0];
        sd       = SD_W'(q_spb) * SD_W'(r_div[DIV_W-1:0]);
        q_dist   = ufbs_pkg::dist16(q_spb);
        cur_dist = ufbs_pkg::dist16(r_spb);

        n_state     = r_state;
        n_clock     = r_clock;
        n_baud      = r_baud;
        n_div       = r_div;
        n_spb       = r_spb;
        n_op        = r_op;
        n_best      = r_best;
        n_best_dist = r_best_dist;
        div_req     = '0;
        mask_start  = 1'b0;

        case (r_state)
            ufbs_pkg::S_IDLE: begin
                if (i_start) begin
                    n_clock     = i_clock;
                    n_baud      = i_baud;
                    n_best      = '0;
                    n_best_dist = DIST_W'(ufbs_pkg::NOMINAL_SAMPLES);
                    if (i_clock == '0 || i_baud == '0) begin
                        n_state = ufbs_pkg::S_RESULT;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {i_clock, {(DVD_W - CLK_W){1'b0}}};
                        div_req.divisor  = DVS_W'(i_baud)
                                           * DVS_W'(ufbs_pkg::NOMINAL_SAMPLES);
                        div_req.nbits    = CNT_W'(CLK_W);
                        n_state          = ufbs_pkg::S_EXACT;
                    end
                end
            end
            ufbs_pkg::S_EXACT: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0
                        && div_rsp.quot <= DVD_W'(ufbs_pkg::MAX_DIVISOR)) begin
                        n_best.found   = 1'b1;
                        n_best.divisor = div_rsp.quot[DIV_W-1:0];
                        n_best.spb     = SPB_W'(ufbs_pkg::NOMINAL_SAMPLES);
                        n_best.mask    = '0;
                        n_state        = ufbs_pkg::S_RESULT;
                    end else begin
                        // first divisor with at most MAX_SAMPLES samples
                        div_req.start    = 1'b1;
                        div_req.dividend = {r_clock, {(DVD_W - CLK_W){1'b0}}};
                        div_req.divisor  = DVS_W'(r_baud)
                                           * DVS_W'(ufbs_pkg::START_MULT);
                        div_req.nbits    = CNT_W'(CLK_W);
                        n_state          = ufbs_pkg::S_START;
                    end
                end
            end
            ufbs_pkg::S_START: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot >= DVD_W'(ufbs_pkg::MAX_DIVISOR)) begin
                        n_state = ufbs_pkg::S_RESULT;
                    end else begin
                        n_div            = DIVC_W'(div_rsp.quot[DIV_W-1:0]) + DIVC_W'(1);
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b1, {(DVD_W - 1){1'b0}}};
                        div_req.divisor  = DVS_W'(r_baud);
                        div_req.nbits    = CNT_W'(FRAC + 1);
                        n_state          = ufbs_pkg::S_RECIP;
                    end
                end
            end
            ufbs_pkg::S_RECIP: begin
                if (div_rsp.done) begin
                    n_op.p_quot = div_rsp.quot[P_W-1:0];
                    n_op.p_rem  = div_rsp.rem[BAUD_W-1:0];
                    n_state     = ufbs_pkg::S_MUL;
                end
            end
            ufbs_pkg::S_MUL: begin
                if (r_div > DIVC_W'(ufbs_pkg::MAX_DIVISOR)) begin
                    n_state = ufbs_pkg::S_RESULT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {r_clock, {(DVD_W - CLK_W){1'b0}}};
                    div_req.divisor  = bd;
                    div_req.nbits    = CNT_W'(CLK_W);
                    n_state          = ufbs_pkg::S_SPB;
                end
            end
            ufbs_pkg::S_SPB: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot < DVD_W'(ufbs_pkg::MIN_SAMPLES)) begin
                        n_state = ufbs_pkg::S_RESULT;
                    end else if (q_dist > r_best_dist) begin
                        // below nominal the distance only grows from here
                        if (q_spb < SPB_W'(ufbs_pkg::NOMINAL_SAMPLES)) begin
                            n_state = ufbs_pkg::S_RESULT;
                        end else begin
                            n_div   = r_div + DIVC_W'(1);
                            n_state = ufbs_pkg::S_MUL;
                        end
                    end else begin
                        n_spb            = q_spb;
                        div_req.start    = 1'b1;
                        div_req.dividend = {sd, {FRAC{1'b0}}};
                        div_req.divisor  = DVS_W'(r_clock);
                        div_req.nbits    = CNT_W'(DVD_W);
                        n_state          = ufbs_pkg::S_AQ;
                    end
                end
            end
            ufbs_pkg::S_AQ: begin
                if (div_rsp.done) begin
                    n_op.a_quot      = div_rsp.quot;
                    n_op.a_rem       = div_rsp.rem[CLK_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {r_div[DIV_W-1:0], {(FRAC + SPB_W){1'b0}}};
                    div_req.divisor  = DVS_W'(r_clock);
                    div_req.nbits    = CNT_W'(B_W);
                    n_state          = ufbs_pkg::S_BQ;
                end
            end
            ufbs_pkg::S_BQ: begin
                if (div_rsp.done) begin
                    n_op.b_quot = div_rsp.quot[B_W-1:0];
                    n_op.b_rem  = div_rsp.rem[CLK_W-1:0];
                    mask_start  = 1'b1;
                    n_state     = ufbs_pkg::S_MASK;
                end
            end
            ufbs_pkg::S_MASK: begin
                if (mask_done) begin
                    if (cur_dist < r_best_dist
                        || (cur_dist == r_best_dist && r_best.mask > mask)) begin
                        n_best.found   = 1'b1;
                        n_best.divisor = r_div[DIV_W-1:0];
                        n_best.spb     = r_spb;
                        n_best.mask    = mask;
                        n_best_dist    = cur_dist;
                    end
                    n_div   = r_div + DIVC_W'(1);
                    n_state = ufbs_pkg::S_MUL;
                end
            end
            ufbs_pkg::S_RESULT: begin
                if (i_res_ready) begin
                    n_state = ufbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ufbs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clock     <= n_clock;
        r_baud      <= n_baud;
        r_div       <= n_div;
        r_spb       <= n_spb;
        r_op        <= n_op;
        r_best      <= n_best;
        r_best_dist <= n_best_dist;
    end

    assign o_idle      = (r_state == ufbs_pkg::S_IDLE);
    assign o_res_valid = (r_state == ufbs_pkg::S_RESULT);
    assign o_res       = r_best;

endmodule

### rtl/core/uart_fractional_baud_search_top.sv
// UART baud setting search.
// Slave channel: one transaction carries a clock frequency and a target bit
// rate. Master channel: one transaction per input with the divisor, the
// samples per bit and the 12-bit stretch mask; tuser is high when a setting
// was found, otherwise all result fields are zero.
// An exact multiple of 16 times the bit rate is answered without a search.
// Otherwise the search steps through the divisors, rejecting some on sample
// count and building the mask for the rest (up to 65535 divisors).
// All of this runs through one radix-2 divider, one bit per cycle, with a
// step through the T2, sum and decide states per mask bit.
// One item is in work at a time: s_tready is high only while the search is
// idle. A finished result sits in the output register; the next item may be
// accepted meanwhile, and its result is held inside until m_tready frees
// the output register.
// Reset (synchronous, active low) drops o_m_tvalid and o_s_tready and returns
// the search to idle; an item in work is lost.
module uart_fractional_baud_search_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [30:0] clock_hz, [54:31] baud_rate
    input  logic [ufbs_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [15:0] divisor, [21:16] samples_per_bit, [33:22] stretch_mask
    output logic [ufbs_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // [0] found
    output logic [0:0]                           o_m_tuser
);

    localparam int CLK_W       = ufbs_pkg::CLK_W;
    localparam int BAUD_W      = ufbs_pkg::BAUD_W;
    localparam int OUT_TDATA_W = ufbs_pkg::OUT_TDATA_W;

    logic              idle;
    logic              res_valid;
    logic              res_ready;
    logic              start;
    ufbs_pkg::t_result res;

    logic              r_m_valid, n_m_valid;
    ufbs_pkg::t_result r_m_res, n_m_res;

    assign o_s_tready = idle & i_rst_n;
    assign start      = i_s_tvalid & o_s_tready;
    assign res_ready  = !r_m_valid || i_m_tready;

    ufbs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_clock     (i_s_tdata[CLK_W-1:0]),
        .i_baud      (i_s_tdata[CLK_W+BAUD_W-1:CLK_W]),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_res   = r_m_res;
        if (res_valid && res_ready) begin
            n_m_valid = 1'b1;
            n_m_res   = res;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_res <= n_m_res;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_m_res.mask, r_m_res.spb, r_m_res.divisor});
    assign o_m_tuser  = r_m_res.found;

endmodule

### test/uart_fractional_baud_search_top_tb.sv
`timescale 1ns / 100ps

module uart_fractional_baud_search_top_tb;

    typedef struct {
        logic [ufbs_pkg::CLK_W-1:0]  clock_hz;
        logic [ufbs_pkg::BAUD_W-1:0] baud;
        bit                          drain_first;
    } t_rate_req;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [ufbs_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    logic [ufbs_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic [0:0]                       o_m_tuser;

    t_rate_req         rate_q[$];
    ufbs_pkg::t_result settings_due[$];

    int     req_sent = 0;
    int     req_taken = 0;
    int     res_taken = 0;
    int     res_seen = 0;
    int     send_gap = 0;
    int     ready_hold = 0;
    bit     send_burst = 0;
    bit     ready_burst = 0;
    int     mismatches = 0;
    int     n_exact = 0;
    int     n_searched = 0;
    int     n_none = 0;
    longint cycles = 0;
    longint cycle_limit = 100000;

    uart_fractional_baud_search_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned off_nominal(input longint unsigned spb);
        if (spb >= ufbs_pkg::NOMINAL_SAMPLES) begin
            return 32'(spb - ufbs_pkg::NOMINAL_SAMPLES);
        end
        return 32'(ufbs_pkg::NOMINAL_SAMPLES - spb);
    endfunction

    // one extra sample on bit i whenever the ideal bit edge runs more than half a sample ahead of the sampled one
    function automatic logic [ufbs_pkg::MASK_BITS-1:0] stretch_mask(
        input longint unsigned clk_hz,
        input longint unsigned baud,
        input longint unsigned spb,
        input longint unsigned div);
        longint unsigned unit;
        longint unsigned acc;
        longint unsigned cnt;
        longint          ideal;
        longint          sampled;
        longint          half;
        longint          err;
        logic [ufbs_pkg::MASK_BITS-1:0] m;
        unit = 64'd1 << ufbs_pkg::FRACTION_BITS;
        acc  = 0;
        m    = '0;
        for (int i = 0; i < ufbs_pkg::MASK_BITS; i++) begin
            cnt     = spb;
            ideal   = (64'(i + 1) * unit) / baud;
            sampled = ((acc + cnt) * div * unit) / clk_hz;
            half    = (div * unit) / (2 * clk_hz);
            err     = ideal - sampled - half;
            if (err > 0) begin
                cnt  = cnt + 1;
                m[i] = 1'b1;
            end
            acc = acc + cnt;
        end
        return m;
    endfunction

    function automatic ufbs_pkg::t_result search_setting(
        input logic [ufbs_pkg::CLK_W-1:0]  clk_in,
        input logic [ufbs_pkg::BAUD_W-1:0] baud_in,
        output longint unsigned tried,
        output longint unsigned built);
        ufbs_pkg::t_result              res;
        longint unsigned                clk_hz;
        longint unsigned                baud;
        longint unsigned                q;
        longint unsigned                spb;
        longint unsigned                best_spb;
        longint unsigned                best_div;
        logic [ufbs_pkg::MASK_BITS-1:0] best_mask;
        logic [ufbs_pkg::MASK_BITS-1:0] m;
        res       = '0;
        tried     = 0;
        built     = 0;
        clk_hz    = 64'(clk_in);
        baud      = 64'(baud_in);
        best_spb  = 0;
        best_div  = 0;
        best_mask = '0;
        if (baud == 0 || clk_hz == 0) begin
            return res;
        end
        if (clk_hz % (16 * baud) == 0) begin
            q = clk_hz / (16 * baud);
            if (q >= 1 && q <= ufbs_pkg::MAX_DIVISOR) begin
                res.divisor = q[ufbs_pkg::DIV_W-1:0];
                res.spb     = ufbs_pkg::SPB_W'(ufbs_pkg::NOMINAL_SAMPLES);
                res.found   = 1'b1;
                return res;
            end
        end
        for (longint unsigned div = 1; div <= ufbs_pkg::MAX_DIVISOR; div++) begin
            tried++;
            spb = clk_hz / (baud * div);
            if (spb > ufbs_pkg::MAX_SAMPLES) begin
                continue;
            end
            if (spb < ufbs_pkg::MIN_SAMPLES) begin
                break;
            end
            built++;
            m = stretch_mask(clk_hz, baud, spb, div);
            if (off_nominal(spb) < off_nominal(best_spb) ||
                (off_nominal(spb) == off_nominal(best_spb) && best_mask > m)) begin
                best_div  = div;
                best_spb  = spb;
                best_mask = m;
            end
        end
        if (best_spb != 0) begin
            res.divisor = best_div[ufbs_pkg::DIV_W-1:0];
            res.spb     = best_spb[ufbs_pkg::SPB_W-1:0];
            res.mask    = best_mask;
            res.found   = 1'b1;
        end
        return res;
    endfunction

    task automatic add_request(input longint unsigned clk_hz, input longint unsigned baud,
                               input bit drain_first);
        t_rate_req r;
        r.clock_hz    = clk_hz[ufbs_pkg::CLK_W-1:0];
        r.baud        = baud[ufbs_pkg::BAUD_W-1:0];
        r.drain_first = drain_first;
        rate_q.push_back(r);
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_rate_req r;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && req_taken != req_sent) begin
            // transaction still pending
        end else if (send_gap > 0) begin
            send_gap--;
            i_s_tvalid <= 1'b0;
        end else if (rate_q.size() > 0 && rate_q[0].drain_first && settings_due.size() > 0) begin
            i_s_tvalid <= 1'b0;
        end else if (rate_q.size() > 0) begin
            r = rate_q.pop_front();
            i_s_tdata  <= ufbs_pkg::IN_TDATA_W'({r.baud, r.clock_hz});
            i_s_tvalid <= 1'b1;
            req_sent++;
            if ($urandom_range(0, 15) == 0) begin
                send_burst = !send_burst;
            end
            send_gap = send_burst ? 0 : $urandom_range(0, 8);
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // result sink stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (res_seen != res_taken) begin
                res_seen = res_taken;
                if ($urandom_range(0, 15) == 0) begin
                    ready_burst = !ready_burst;
                end
                ready_hold = ready_burst ? 0 : $urandom_range(0, 8);
            end
            if (o_m_tvalid && ready_hold > 0) begin
                ready_hold--;
            end
            i_m_tready <= (ready_hold == 0);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        ufbs_pkg::t_result want;
        ufbs_pkg::t_result got;
        longint unsigned   tried;
        longint unsigned   built;
        cycles++;
        if (cycles > cycle_limit) begin
            $display("%0t ns: timeout after %0d cycles, %0d settings outstanding",
                     $time, cycles, settings_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                want = search_setting(
                    i_s_tdata[ufbs_pkg::CLK_W-1:0],
                    i_s_tdata[ufbs_pkg::CLK_W+ufbs_pkg::BAUD_W-1:ufbs_pkg::CLK_W],
                    tried, built);
                settings_due.push_back(want);
                cycle_limit += 4 * (200 + 40 * tried + 200 * built);
                req_taken++;
                if (!want.found) begin
                    n_none++;
                end else if (tried == 0) begin
                    n_exact++;
                end else begin
                    n_searched++;
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                got.divisor = o_m_tdata[ufbs_pkg::DIV_W-1:0];
                got.spb     = o_m_tdata[ufbs_pkg::DIV_W+ufbs_pkg::SPB_W-1:ufbs_pkg::DIV_W];
                got.mask    = o_m_tdata[ufbs_pkg::OUT_DATA_W-1:
                                        ufbs_pkg::DIV_W+ufbs_pkg::SPB_W];
                got.found   = o_m_tuser[0];
                res_taken++;
                if (settings_due.size() == 0) begin
                    $display("%0t ns: unexpected result div=%0d spb=%0d mask=%03h found=%0d",
                             $time, got.divisor, got.spb, got.mask, got.found);
                    mismatches++;
                end else begin
                    want = settings_due.pop_front();
                    if (got !== want) begin
                        $display("%0t ns: expected div=%0d spb=%0d mask=%03h found=%0d, %s",
                                 $time, want.divisor, want.spb, want.mask, want.found,
                                 $sformatf("got div=%0d spb=%0d mask=%03h found=%0d",
                                           got.divisor, got.spb, got.mask, got.found));
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        longint unsigned baud;
        longint unsigned clk_hz;
        longint unsigned ratio;
        longint unsigned off;
        int              pick;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;

        // directed
        add_request(0, 0, 0);
        add_request(0, 9600, 0);
        add_request(1000000, 0, 0);
        add_request(64'h7FFF_FFFF, 64'hFF_FFFF, 0);
        add_request(1, 1, 0);
        add_request(3, 1, 0);
        add_request(4, 1, 0);
        add_request(16, 1, 0);
        add_request(16 * 65535, 1, 0);
        add_request(33, 1, 0);
        add_request(32 * 9600 + 1, 9600, 0);
        add_request(50000000, 115200, 1);
        add_request(1843200, 115200, 0);
        add_request(12000000, 9600, 0);
        add_request(24000000, 115200, 0);
        add_request(64'h7FFF_FFFF, 64'h80_0000, 0);
        add_request(64'h4000_0000, 64'hFF_FFFF, 0);
        add_request(100, 7, 0);
        add_request(16 * 65536, 1, 1);
        add_request(14745600, 921600, 0);

        // random
        for (int n = 0; n < 100; n++) begin
            baud = 64'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 23));
            if (baud == 0) begin
                baud = 1;
            end
            pick = $urandom_range(0, 9);
            off  = $urandom_range(0, 32'(baud - 1));
            if (pick == 0) begin
                ratio = $urandom_range(1, 5);
            end else if (pick == 1) begin
                ratio = 16 * $urandom_range(1, 40);
                off   = 0;
            end else if (pick == 2) begin
                ratio = $urandom_range(300, 1500);
            end else begin
                ratio = $urandom_range(4, 200);
            end
            clk_hz = baud * ratio + off;
            if (clk_hz > 64'h7FFF_FFFF) begin
                clk_hz = 64'h7FFF_FFFF;
            end
            add_request(clk_hz, baud, (n % 25) == 12);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (rate_q.size() > 0 || i_s_tvalid || settings_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);

        $display("%0d rate requests: %0d exact multiples, %0d by divisor search, %0d unreachable",
                 req_taken, n_exact, n_searched, n_none);
        $display("%0d results checked in %0d cycles", res_taken, cycles);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### uart_fractional_baud_search_top.f
rtl/core/ufbs_pkg.sv
rtl/core/ufbs_divider.sv
rtl/core/ufbs_mask.sv
rtl/core/ufbs_seq.sv
rtl/core/uart_fractional_baud_search_top.sv
test/uart_fractional_baud_search_top_tb.sv
